>>> rtl/assert_macros.svh
// assertion macros of the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define VEF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define VEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/vef_pkg.sv
// types and constants of the visibility edge filter
`default_nettype none
package vef_pkg;

  localparam int DEF_MAX_EDGES  = 64;
  localparam int DEF_MAX_RECTS  = 16;
  localparam int DEF_COORD_BITS = 16;
  localparam int SEG_COUNT_W    = 7;
  localparam int RECT_COUNT_W   = 5;
  localparam int CROSS_LAT      = 4;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  typedef enum logic [1:0] {
    CMD_LOAD_EDGE   = 2'd0,
    CMD_LOAD_CORNER = 2'd1,
    CMD_QUERY       = 2'd2,
    CMD_NONE        = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    VERDICT_MATCH   = 2'd0,
    VERDICT_CLEAR   = 2'd1,
    VERDICT_DIAG    = 2'd2,
    VERDICT_BLOCKED = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RUN    = 2'd1,
    ST_DRAIN  = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

  typedef enum logic {
    REG_SEG_COUNT  = 1'b0,
    REG_RECT_COUNT = 1'b1
  } reg_idx_t;

endpackage
`default_nettype wire

>>> rtl/vef_edge_cell.sv
// one cell of the rotating edge ring
`default_nettype none
module vef_edge_cell #(
  parameter int W = 16
) (
  input  wire logic           clk,
  input  wire logic           load_en,
  input  wire logic [4*W-1:0] load_data,
  input  wire logic           shift_en,
  input  wire logic [4*W-1:0] nbr_data,
  output logic      [4*W-1:0] held
);

  logic [4*W-1:0] data_r;
  logic [4*W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load_en) begin
      data_nxt = load_data;
    end else if (shift_en) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign held = data_r;

endmodule
`default_nettype wire

>>> rtl/vef_rect_cell.sv
// one cell of the rotating rectangle ring, four corners
`default_nettype none
module vef_rect_cell #(
  parameter int W = 16
) (
  input  wire logic           clk,
  input  wire logic           load_en,
  input  wire logic [1:0]     load_corner,
  input  wire logic [2*W-1:0] load_pt,
  input  wire logic           shift_en,
  input  wire logic [8*W-1:0] nbr_data,
  output logic      [8*W-1:0] held
);

  logic [8*W-1:0] data_r;
  logic [8*W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load_en) begin
      data_nxt[load_corner*(2*W) +: 2*W] = load_pt;
    end else if (shift_en) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign held = data_r;

endmodule
`default_nettype wire

>>> rtl/vef_cross_unit.sv
// pipelined crossing test of one edge against the query segment
`default_nettype none
module vef_cross_unit #(
  parameter int W = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_vld,
  input  wire logic signed [W-1:0] e0x,
  input  wire logic signed [W-1:0] e0y,
  input  wire logic signed [W-1:0] e1x,
  input  wire logic signed [W-1:0] e1y,
  input  wire logic signed [W-1:0] ax,
  input  wire logic signed [W-1:0] ay,
  input  wire logic signed [W:0]   s2x,
  input  wire logic signed [W:0]   s2y,
  output logic                     hit
);

  localparam int PW = 2*W + 2;
  localparam int SW = 2*W + 3;

  logic                 v1_r, v2_r, v3_r, hit_r;
  logic signed [W:0]    s1x_r, s1y_r, dx_r, dy_r;
  logic signed [PW-1:0] p_a_r, p_b_r, p_c_r, p_d_r, p_e_r, p_f_r;
  logic signed [SW-1:0] d_r, sn_r, tn_r;
  logic                 hit_nxt, pos, neg, sn_pos, sn_neg, tn_neg;

  always_ff @(posedge clk) begin
    s1x_r <= (W+1)'(e1x) - (W+1)'(e0x);
    s1y_r <= (W+1)'(e1y) - (W+1)'(e0y);
    dx_r  <= (W+1)'(e0x) - (W+1)'(ax);
    dy_r  <= (W+1)'(e0y) - (W+1)'(ay);
    p_a_r <= PW'(s1x_r) * PW'(s2y);
    p_b_r <= PW'(s2x) * PW'(s1y_r);
    p_c_r <= PW'(s1x_r) * PW'(dy_r);
    p_d_r <= PW'(s1y_r) * PW'(dx_r);
    p_e_r <= PW'(s2x) * PW'(dy_r);
    p_f_r <= PW'(s2y) * PW'(dx_r);
    d_r   <= SW'(p_a_r) - SW'(p_b_r);
    sn_r  <= SW'(p_c_r) - SW'(p_d_r);
    tn_r  <= SW'(p_e_r) - SW'(p_f_r);
  end

  always_comb begin
    neg     = d_r[SW-1];
    pos     = !d_r[SW-1] && (d_r != '0);
    sn_neg  = sn_r[SW-1];
    sn_pos  = !sn_r[SW-1] && (sn_r != '0);
    tn_neg  = tn_r[SW-1];
    hit_nxt = 1'b0;
    if (pos) begin
      hit_nxt = sn_pos && (sn_r < d_r) && !tn_neg && (tn_r <= d_r);
    end else if (neg) begin
      hit_nxt = sn_neg && (sn_r > d_r) && (tn_neg || tn_r == '0) && (tn_r >= d_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v1_r  <= in_vld;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      hit_r <= v3_r && hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule
`default_nettype wire

>>> rtl/visibility_edge_filter_core.sv
// top level of the visibility edge filter
// Channels: input words carry a command (load edge, load rectangle corner,
// query) with slot, corner and two points; each query yields one output
// word of keep and verdict, loads yield none. Configuration is an APB-style
// port with segment_count at address 0 and rectangle_count at address 4.
// A load writes its table cell in the next cycle. A query runs while the edge
// and rectangle rings each rotate once past a single compare point, then
// drains the crossing multiplier pipeline and finishes; its result word is
// loaded into the output register from the finish state.
// One query is in work at a time; in_stall is high from the accepted query
// until its result is in the output register.
// The output register holds the word while out_stall is high; a finished
// query waits for it and the input stays stalled meanwhile.
// Reset clears the control and the counts; table entries are undefined until
// loaded and must be loaded before a query reads them.
`default_nettype none
module visibility_edge_filter_core #(
  parameter int MAX_EDGES  = vef_pkg::DEF_MAX_EDGES,
  parameter int MAX_RECTS  = vef_pkg::DEF_MAX_RECTS,
  parameter int COORD_BITS = vef_pkg::DEF_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_cmd,
  input  wire logic [5:0]                   in_slot,
  input  wire logic [1:0]                   in_corner,
  input  wire logic signed [COORD_BITS-1:0] in_first_x,
  input  wire logic signed [COORD_BITS-1:0] in_first_y,
  input  wire logic signed [COORD_BITS-1:0] in_second_x,
  input  wire logic signed [COORD_BITS-1:0] in_second_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_keep,
  output logic [1:0]                        out_verdict,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [vef_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [vef_pkg::DATA_W-1:0]   pwdata,
  output logic      [vef_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  `include "assert_macros.svh"

  localparam int W     = COORD_BITS;
  localparam int LEN   = (MAX_EDGES > MAX_RECTS) ? MAX_EDGES : MAX_RECTS;
  localparam int STW   = $clog2(LEN + vef_pkg::CROSS_LAT);
  localparam int SCW   = vef_pkg::SEG_COUNT_W;
  localparam int RCW   = vef_pkg::RECT_COUNT_W;

  vef_pkg::state_t   state_r, state_nxt;
  logic [STW-1:0]    step_r, step_nxt;
  logic [SCW-1:0]    seg_count_r;
  logic [RCW-1:0]    rect_count_r;
  logic              match_r, diag_r, cross_r;
  logic              match_nxt, diag_nxt, cross_nxt;
  logic signed [W-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [W:0]   s2x_r, s2y_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_keep_r;
  vef_pkg::verdict_t out_verdict_r, verdict_nxt;

  logic              in_acc, qry_acc, cfg_wr, fin_load, run_end, drain_end;
  logic              edge_shift, rect_shift, edge_live, rect_live;
  logic              edge_match, rect_match, cross_hit;
  logic [4*W-1:0]    edge_held [MAX_EDGES];
  logic [8*W-1:0]    rect_held [MAX_RECTS];
  logic [4*W-1:0]    edge_load;
  logic signed [W-1:0] h_e0x, h_e0y, h_e1x, h_e1y;
  logic [2*W-1:0]    pa, pb, c0, c1, c2, c3, e0, e1;

  assign in_acc  = in_valid && !in_stall;
  assign qry_acc = in_acc && (vef_pkg::cmd_t'(in_cmd) == vef_pkg::CMD_QUERY);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r  <= '0;
      rect_count_r <= '0;
    end else if (cfg_wr) begin
      case (vef_pkg::reg_idx_t'(paddr[2]))
        vef_pkg::REG_SEG_COUNT:  seg_count_r  <= pwdata[SCW-1:0];
        vef_pkg::REG_RECT_COUNT: rect_count_r <= pwdata[RCW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (vef_pkg::reg_idx_t'(paddr[2]))
      vef_pkg::REG_SEG_COUNT:  prdata = vef_pkg::DATA_W'(seg_count_r);
      vef_pkg::REG_RECT_COUNT: prdata = vef_pkg::DATA_W'(rect_count_r);
      default:                 prdata = '0;
    endcase
  end

  // edge and rectangle rings
  assign edge_shift = (state_r == vef_pkg::ST_RUN) && (32'(step_r) < MAX_EDGES);
  assign rect_shift = (state_r == vef_pkg::ST_RUN) && (32'(step_r) < MAX_RECTS);
  assign edge_live  = edge_shift && (32'(step_r) < 32'(seg_count_r));
  assign rect_live  = rect_shift && (32'(step_r) < 32'(rect_count_r));
  assign edge_load  = {in_first_x, in_first_y, in_second_x, in_second_y};

  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_edge
    vef_edge_cell #(.W(W)) u_cell (
      .clk       (clk),
      .load_en   (in_acc && (vef_pkg::cmd_t'(in_cmd) == vef_pkg::CMD_LOAD_EDGE)
                  && (32'(in_slot) == i)),
      .load_data (edge_load),
      .shift_en  (edge_shift),
      .nbr_data  (edge_held[(i + 1) % MAX_EDGES]),
      .held      (edge_held[i])
    );
  end

  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_rect
    vef_rect_cell #(.W(W)) u_cell (
      .clk         (clk),
      .load_en     (in_acc && (vef_pkg::cmd_t'(in_cmd) == vef_pkg::CMD_LOAD_CORNER)
                    && (32'(in_slot) == i)),
      .load_corner (in_corner),
      .load_pt     ({in_first_x, in_first_y}),
      .shift_en    (rect_shift),
      .nbr_data    (rect_held[(i + 1) % MAX_RECTS]),
      .held        (rect_held[i])
    );
  end

  // compare point at the ring heads
  assign {h_e0x, h_e0y, h_e1x, h_e1y} = edge_held[0];
  assign e0 = {h_e0x, h_e0y};
  assign e1 = {h_e1x, h_e1y};
  assign pa = {ax_r, ay_r};
  assign pb = {bx_r, by_r};
  assign c0 = rect_held[0][0*2*W +: 2*W];
  assign c1 = rect_held[0][1*2*W +: 2*W];
  assign c2 = rect_held[0][2*2*W +: 2*W];
  assign c3 = rect_held[0][3*2*W +: 2*W];

  assign edge_match = (e0 == pa && e1 == pb) || (e0 == pb && e1 == pa);
  assign rect_match = (c0 == pa && c2 == pb) || (c1 == pb && c3 == pa) ||
                      (c2 == pa && c0 == pb) || (c3 == pb && c1 == pa);

  vef_cross_unit #(.W(W)) u_cross (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (edge_live),
    .e0x    (h_e0x),
    .e0y    (h_e0y),
    .e1x    (h_e1x),
    .e1y    (h_e1y),
    .ax     (ax_r),
    .ay     (ay_r),
    .s2x    (s2x_r),
    .s2y    (s2y_r),
    .hit    (cross_hit)
  );

  // query word
  always_ff @(posedge clk) begin
    if (qry_acc) begin
      ax_r  <= in_first_x;
      ay_r  <= in_first_y;
      bx_r  <= in_second_x;
      by_r  <= in_second_y;
      s2x_r <= (W+1)'(in_second_x) - (W+1)'(in_first_x);
      s2y_r <= (W+1)'(in_second_y) - (W+1)'(in_first_y);
    end
  end

  // sequencer
  assign run_end   = (state_r == vef_pkg::ST_RUN) && (32'(step_r) == LEN - 1);
  assign drain_end = (state_r == vef_pkg::ST_DRAIN) &&
                     (32'(step_r) == vef_pkg::CROSS_LAT - 1);
  assign fin_load  = (state_r == vef_pkg::ST_FINISH) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vef_pkg::ST_IDLE:   if (qry_acc)   state_nxt = vef_pkg::ST_RUN;
      vef_pkg::ST_RUN:    if (run_end)   state_nxt = vef_pkg::ST_DRAIN;
      vef_pkg::ST_DRAIN:  if (drain_end) state_nxt = vef_pkg::ST_FINISH;
      vef_pkg::ST_FINISH: if (fin_load)  state_nxt = vef_pkg::ST_IDLE;
      default:                           state_nxt = vef_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      vef_pkg::ST_IDLE: in_stall = 1'b0;
      default:          in_stall = 1'b1;
    endcase
  end

  always_comb begin
    step_nxt = '0;
    if (((state_r == vef_pkg::ST_RUN) && !run_end) ||
        ((state_r == vef_pkg::ST_DRAIN) && !drain_end)) begin
      step_nxt = step_r + 1'b1;
    end
    match_nxt = match_r || (edge_live && edge_match);
    diag_nxt  = diag_r || (rect_live && rect_match);
    cross_nxt = cross_r || cross_hit;
    if (qry_acc) begin
      match_nxt = 1'b0;
      diag_nxt  = 1'b0;
      cross_nxt = 1'b0;
    end
    if (match_r) begin
      verdict_nxt = vef_pkg::VERDICT_MATCH;
    end else if (diag_r) begin
      verdict_nxt = vef_pkg::VERDICT_DIAG;
    end else if (cross_r) begin
      verdict_nxt = vef_pkg::VERDICT_BLOCKED;
    end else begin
      verdict_nxt = vef_pkg::VERDICT_CLEAR;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (fin_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vef_pkg::ST_IDLE;
      step_r      <= '0;
      match_r     <= 1'b0;
      diag_r      <= 1'b0;
      cross_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      match_r     <= match_nxt;
      diag_r      <= diag_nxt;
      cross_r     <= cross_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_verdict_r <= verdict_nxt;
      out_keep_r    <= (verdict_nxt == vef_pkg::VERDICT_MATCH) ||
                       (verdict_nxt == vef_pkg::VERDICT_CLEAR);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_keep    = out_keep_r;
  assign out_verdict = out_verdict_r;

  `VEF_ASSERT_NEXT(a_query_starts_run, clk, rst_n, qry_acc, state_r == vef_pkg::ST_RUN,
    "query accepted but sequencer not running")
  `VEF_ASSERT_NOW(a_result_from_finish, clk, rst_n, $rose(out_valid_r),
    $past(state_r) == vef_pkg::ST_FINISH, "result appeared outside finish")
  `VEF_ASSERT_NOW(a_keep_matches_verdict, clk, rst_n, out_valid_r,
    out_keep_r == (out_verdict_r == vef_pkg::VERDICT_MATCH ||
    out_verdict_r == vef_pkg::VERDICT_CLEAR), "keep disagrees with verdict")
  `VEF_ASSERT_NOW(a_rings_still_when_idle, clk, rst_n, state_r == vef_pkg::ST_IDLE,
    !edge_shift && !rect_shift && step_r == '0, "ring moved outside a query")

endmodule
`default_nettype wire
